// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for the clocked, reset-gated checks used in the RTL. The using
// scope must provide clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/maa_pkg.sv =====
// ---------------------------------------------------------------------------
// maa_pkg
// Types and constants shared by the address aging table and its cells.
// ---------------------------------------------------------------------------
package maa_pkg;

    // Operation codes carried on the item channel.
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_REPORT  = 1'b1;

    // Frame filter: minimum length and the accepted management subtypes.
    localparam logic [11:0] MIN_FRAME_LEN     = 12'd24;
    localparam logic [3:0]  SUBTYPE_ASSOC_REQ = 4'h0;
    localparam logic [3:0]  SUBTYPE_PROBE_REQ = 4'h4;
    localparam logic [3:0]  SUBTYPE_BEACON    = 4'h8;

    localparam logic [31:0] TIMEOUT_RESET = 32'd300000;
    localparam logic [15:0] TOTAL_MAX     = 16'hFFFF;
    localparam logic [6:0]  ACTIVE_MAX    = 7'd127;

    typedef enum logic [1:0] {
        EV_IGNORED   = 2'd0,
        EV_REFRESHED = 2'd1,
        EV_STORED    = 2'd2,
        EV_REPORT    = 2'd3
    } maa_event_t;

    typedef struct packed {
        logic        operation;
        logic        is_management;
        logic [11:0] frame_length;
        logic [7:0]  frame_control_byte;
        logic [47:0] source_mac;
        logic [31:0] now_ms;
    } maa_item_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [5:0]  slot;
        logic [15:0] unique_count;
        logic [6:0]  active_count;
    } maa_result_t;

    // Search token handed from cell to cell along the table.
    typedef struct packed {
        logic       run;
        logic       report;
        logic       found;
        logic [6:0] active_count;
    } maa_token_t;

endpackage

// ===== src/maa_item_if.sv =====
// ---------------------------------------------------------------------------
// maa_item_if
// Valid/ready channel carrying one request item per beat.
// ---------------------------------------------------------------------------
interface maa_item_if;
    logic              valid;
    logic              ready;
    maa_pkg::maa_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/maa_result_if.sv =====
// ---------------------------------------------------------------------------
// maa_result_if
// Valid/ready channel carrying one result item per beat.
// ---------------------------------------------------------------------------
interface maa_result_if;
    logic                valid;
    logic                ready;
    maa_pkg::maa_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/maa_cell.sv =====
// ---------------------------------------------------------------------------
// maa_cell
// One table entry with its own comparator, age check and token register.
// ---------------------------------------------------------------------------
module maa_cell #(
    parameter int IDX_W      = 6,
    parameter int CELL_INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  maa_pkg::maa_token_t tok_in,
    input  logic [IDX_W-1:0]  slot_in,
    output maa_pkg::maa_token_t tok_out,
    output logic [IDX_W-1:0]  slot_out,
    input  logic [47:0]       mac,
    input  logic [31:0]       now_ms,
    input  logic [31:0]       timeout_ms,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_slot
);
    import maa_pkg::*;

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

    logic        valid_reg;
    logic [47:0] address_reg;
    logic [31:0] last_seen_reg;
    maa_token_t  tok_reg;
    maa_token_t  tok_next;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] slot_next;

    logic [31:0] age;
    logic        is_active;
    logic        is_match;
    logic        take_hit;
    logic        take_insert;

    assign age         = now_ms - last_seen_reg;
    assign is_active   = valid_reg && (age < timeout_ms);
    assign is_match    = valid_reg && (address_reg == mac);
    assign take_hit    = tok_in.run && !tok_in.report && !tok_in.found && is_match;
    assign take_insert = wr_en && (wr_slot == MY_INDEX);

    always_comb
    begin
        tok_next  = tok_in;
        slot_next = slot_in;
        if (tok_in.run && tok_in.report && is_active && (tok_in.active_count != ACTIVE_MAX))
        begin
            tok_next.active_count = tok_in.active_count + 7'd1;
        end
        if (take_hit)
        begin
            tok_next.found = 1'b1;
            slot_next      = MY_INDEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (take_insert)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    // Entry contents are only ever read behind the valid bit.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        if (take_insert)
        begin
            address_reg   <= mac;
            last_seen_reg <= now_ms;
        end
        else if (take_hit)
        begin
            last_seen_reg <= now_ms;
        end
    end

    assign tok_out  = tok_reg;
    assign slot_out = slot_reg;

endmodule

// ===== src/mac_address_aging_table.sv =====
// ---------------------------------------------------------------------------
// mac_address_aging_table
// Learning table of wireless source addresses with last-seen aging.
// ---------------------------------------------------------------------------
// Usage. Requests arrive as beats on the item channel and every request
// produces exactly one beat on the result channel. An observe beat carries a
// sniffed frame; frames that are not management, are shorter than 24 bytes or
// are not an association request, probe request or beacon are ignored at
// once. Accepted frames search the table, refreshing a known address or
// storing a new one at the round-robin insert pointer. A report beat returns
// the number of entries seen less than the timeout ago, plus the insert count.
// Timing: a search token walks a row of TABLE_ENTRIES cells, one cell per
// cycle. A search result is held when the token leaves the last cell, an
// ignored frame's result on acceptance; it goes to the output register once
// that is free. The next request can be accepted in the cycle result valid
// rises, not before. The user must write the timeout register through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
// Reset clears all valid bits, the insert pointer and the insert counter and
// loads the timeout with 300000 ms. If the receiver stalls, the finished
// result waits in the output register; one further request is still taken
// and processed, its result then waits inside the block, and no new request
// is taken until the output register has been handed over.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mac_address_aging_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    maa_item_if.sink    item,
    maa_result_if.source result,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import maa_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic [31:0] timeout_reg;
    logic [IDX_W-1:0] insert_ptr_reg;
    logic [15:0] insert_total_reg;
    maa_token_t  launch_reg;

    // Request held stable while its token walks the chain.
    logic [47:0] mac_reg;
    logic [31:0] now_reg;

    // Result waiting for the output register.
    maa_event_t  pend_event_reg;
    logic [5:0]  pend_slot_reg;
    logic [6:0]  pend_active_reg;

    logic        out_valid_reg;
    maa_result_t out_data_reg;

    // Token and slot wires between neighbouring cells.
    maa_token_t       chain_tok  [0:TABLE_ENTRIES];
    logic [IDX_W-1:0] chain_slot [0:TABLE_ENTRIES];

    logic             item_fire;
    logic             frame_ok;
    logic [3:0]       subtype;
    logic             end_run;
    maa_token_t       end_tok;
    logic             wr_en;
    logic [IDX_W-1:0] hit_slot;
    logic [IDX_W+5:0] hit_slot_wide;
    logic [IDX_W+5:0] ins_slot_wide;
    logic             out_free;

    assign item.ready = (state_reg == S_IDLE);
    assign item_fire  = item.valid && item.ready;
    assign subtype    = item.data.frame_control_byte[7:4];
    assign frame_ok   = item.data.is_management &&
                        (item.data.frame_length >= MIN_FRAME_LEN) &&
                        ((subtype == SUBTYPE_ASSOC_REQ) ||
                         (subtype == SUBTYPE_PROBE_REQ) ||
                         (subtype == SUBTYPE_BEACON));

    assign end_tok = chain_tok[TABLE_ENTRIES];
    assign end_run = (state_reg == S_SCAN) && end_tok.run;
    assign hit_slot = chain_slot[TABLE_ENTRIES];

    // A miss writes the new entry in the same cycle as the token leaves.
    assign wr_en = end_run && !end_tok.report && !end_tok.found;

    // Slot numbers are reported modulo 64.
    assign hit_slot_wide = {6'd0, hit_slot};
    assign ins_slot_wide = {6'd0, insert_ptr_reg};

    assign out_free = !out_valid_reg || result.ready;

    assign chain_tok[0]  = launch_reg;
    assign chain_slot[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        maa_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .tok_in     (chain_tok[g]),
            .slot_in    (chain_slot[g]),
            .tok_out    (chain_tok[g+1]),
            .slot_out   (chain_slot[g+1]),
            .mac        (mac_reg),
            .now_ms     (now_reg),
            .timeout_ms (timeout_reg),
            .wr_en      (wr_en),
            .wr_slot    (insert_ptr_reg)
        );
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            mac_reg <= item.data.source_mac;
            now_reg <= item.data.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            timeout_reg      <= TIMEOUT_RESET;
            insert_ptr_reg   <= '0;
            insert_total_reg <= '0;
            launch_reg       <= '0;
            pend_event_reg   <= EV_IGNORED;
            pend_slot_reg    <= '0;
            pend_active_reg  <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            launch_reg.run <= 1'b0;

            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end

            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_fire)
                    begin
                        if ((item.data.operation == OP_REPORT) || frame_ok)
                        begin
                            launch_reg.run          <= 1'b1;
                            launch_reg.report       <= (item.data.operation == OP_REPORT);
                            launch_reg.found        <= 1'b0;
                            launch_reg.active_count <= '0;
                            state_reg               <= S_SCAN;
                        end
                        else
                        begin
                            pend_event_reg  <= EV_IGNORED;
                            pend_slot_reg   <= '0;
                            pend_active_reg <= '0;
                            state_reg       <= S_DONE;
                        end
                    end
                end

                S_SCAN:
                begin
                    if (end_run)
                    begin
                        if (end_tok.report)
                        begin
                            pend_event_reg  <= EV_REPORT;
                            pend_slot_reg   <= '0;
                            pend_active_reg <= end_tok.active_count;
                        end
                        else if (end_tok.found)
                        begin
                            pend_event_reg  <= EV_REFRESHED;
                            pend_slot_reg   <= hit_slot_wide[5:0];
                            pend_active_reg <= '0;
                        end
                        else
                        begin
                            pend_event_reg  <= EV_STORED;
                            pend_slot_reg   <= ins_slot_wide[5:0];
                            pend_active_reg <= '0;
                            if (insert_ptr_reg == LAST_INDEX)
                            begin
                                insert_ptr_reg <= '0;
                            end
                            else
                            begin
                                insert_ptr_reg <= insert_ptr_reg + IDX_W'(1);
                            end
                            if (insert_total_reg != TOTAL_MAX)
                            begin
                                insert_total_reg <= insert_total_reg + 16'd1;
                            end
                        end
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_data_reg.event_res    <= pend_event_reg;
                        out_data_reg.slot         <= pend_slot_reg;
                        out_data_reg.unique_count <= insert_total_reg;
                        out_data_reg.active_count <= pend_active_reg;
                        state_reg                 <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // A token may only reach the end of the chain while a search is pending.
    `ASSERT_IMPLIES(a_token_only_in_scan, end_tok.run, state_reg == S_SCAN)

    // The insert pointer never leaves the table.
    `ASSERT_IMPLIES(a_ptr_in_range, 1'b1, insert_ptr_reg <= LAST_INDEX)

    // The insert counter only ever holds or steps up by one.
    `ASSERT_NEXT(a_total_steps, 1'b1,
                 (insert_total_reg == $past(insert_total_reg)) ||
                 (insert_total_reg == $past(insert_total_reg) + 16'd1))

    // A new entry is written only when the search found no match.
    `ASSERT_IMPLIES(a_insert_on_miss, wr_en, end_run && !end_tok.found && !end_tok.report)

endmodule

// ===== dv/tb_mac_address_aging_table.sv =====
// ---------------------------------------------------------------------------
// tb_mac_address_aging_table
// Self-checking testbench for the address aging table. Request beats are
// driven from a queue, a behavioural copy of the learning table works out the
// result of every accepted beat, and the result beats are compared with it
// field by field. The run covers the timeout at its extremes and at random.
// ---------------------------------------------------------------------------
module tb_mac_address_aging_table;
    import maa_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    // Address pool a little larger than the table, so that well-formed
    // frames both hit known addresses and force round-robin overwrites.
    localparam int MAC_POOL      = 80;
    localparam int LONG_HOLD     = 300;
    localparam int RUN_LIMIT     = 10_000_000;
    localparam logic [31:0] T0   = 32'h0000_1000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_wdata;

    maa_item_if   item_ch ();
    maa_result_if result_ch ();

    mac_address_aging_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Beats waiting to be driven, and the outcomes still owed by the block.
    maa_item_t   pending_items [$];
    maa_result_t outcomes_due [$];

    int send_idle_pct;
    int recv_idle_pct;
    bit rx_hold;
    int beats_taken;
    int fault_count;
    event hold_results;

    // Our own copy of the learning table and its timeout register.
    bit          seen_valid [TABLE_ENTRIES];
    bit [47:0]   seen_mac [TABLE_ENTRIES];
    bit [31:0]   seen_at [TABLE_ENTRIES];
    int          next_slot;
    logic [15:0] insertions;
    logic [31:0] timeout_ms;

    // Stimulus state: a running millisecond clock and the address pool.
    logic [31:0] air_time_ms;
    logic [47:0] mac_pool [MAC_POOL];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The whole run is bounded by a generous fixed time.
    initial
    begin
        #RUN_LIMIT;
        $display("tb_mac_address_aging_table: errors");
        $finish;
    end

    // Works out the result of one accepted request beat and updates the
    // table copy exactly as the block should.
    function automatic maa_result_t table_outcome(maa_item_t beat);
        maa_result_t res;
        logic [3:0]  subtype;
        logic [31:0] age;
        int          active;
        bit          hit;
        res = '0;
        subtype = beat.frame_control_byte[7:4];
        if (beat.operation == OP_REPORT)
        begin
            // Age is a wrapping 32-bit difference, so a time stamp from the
            // "future" looks very old and is not counted.
            active = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                age = beat.now_ms - seen_at[i];
                if (seen_valid[i] && age < timeout_ms)
                    active++;
            end
            res.event_res = EV_REPORT;
            res.active_count = (active > ACTIVE_MAX) ? ACTIVE_MAX : active[6:0];
        end
        else if (!beat.is_management || beat.frame_length < MIN_FRAME_LEN ||
                 !(subtype == SUBTYPE_ASSOC_REQ || subtype == SUBTYPE_PROBE_REQ ||
                   subtype == SUBTYPE_BEACON))
        begin
            res.event_res = EV_IGNORED;
        end
        else
        begin
            hit = 1'b0;
            for (int i = 0; i < TABLE_ENTRIES && !hit; i++)
            begin
                if (seen_valid[i] && seen_mac[i] == beat.source_mac)
                begin
                    seen_at[i] = beat.now_ms;
                    res.event_res = EV_REFRESHED;
                    res.slot = i[5:0];
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                // A miss overwrites the slot under the insert pointer,
                // whatever it held.
                seen_valid[next_slot] = 1'b1;
                seen_mac[next_slot] = beat.source_mac;
                seen_at[next_slot] = beat.now_ms;
                res.event_res = EV_STORED;
                res.slot = next_slot[5:0];
                next_slot = (next_slot + 1) % TABLE_ENTRIES;
                if (insertions != TOTAL_MAX)
                    insertions++;
            end
        end
        res.unique_count = insertions;
        return res;
    endfunction

    function automatic maa_item_t make_item(logic op, logic mgmt, logic [11:0] len,
                                            logic [7:0] fc, logic [47:0] mac,
                                            logic [31:0] now);
        maa_item_t beat;
        beat.operation = op;
        beat.is_management = mgmt;
        beat.frame_length = len;
        beat.frame_control_byte = fc;
        beat.source_mac = mac;
        beat.now_ms = now;
        return beat;
    endfunction

    function automatic logic [47:0] random_mac();
        logic [63:0] word;
        word = {$urandom, $urandom};
        return word[47:0];
    endfunction

    // One random request beat. Most are well-formed frames drawn from the
    // address pool; the rest are reports and frames with arbitrary fields.
    function automatic maa_item_t random_beat(int step_max);
        maa_item_t   beat;
        int          roll;
        logic [3:0]  subtype;
        logic [31:0] now;
        roll = $urandom_range(99);
        air_time_ms = air_time_ms + $urandom_range(step_max);
        now = ($urandom_range(99) < 8) ? $urandom : air_time_ms;
        beat = make_item(OP_OBSERVE, 1'($urandom_range(1)), 12'($urandom_range(4095)),
                         8'($urandom_range(255)), random_mac(), now);
        if (roll < 15)
        begin
            beat.operation = OP_REPORT;
        end
        else if (roll >= 30)
        begin
            case ($urandom_range(2))
                0: subtype = SUBTYPE_ASSOC_REQ;
                1: subtype = SUBTYPE_PROBE_REQ;
                default: subtype = SUBTYPE_BEACON;
            endcase
            beat.is_management = 1'b1;
            beat.frame_length = ($urandom_range(9) == 0) ? 12'hFFF
                                                         : 12'($urandom_range(1600, 24));
            beat.frame_control_byte = {subtype, 4'($urandom_range(15))};
            if ($urandom_range(19) != 0)
                beat.source_mac = mac_pool[$urandom_range(MAC_POOL - 1)];
        end
        return beat;
    endfunction

    function automatic void note_failure(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: mismatch: %s", $realtime, msg);
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
            note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    // Driver: a new beat is put up only once the previous one has been taken
    // (or nothing was offered), so valid never drops under a waiting beat.
    always @(posedge clk)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_ch.data <= pending_items.pop_front();
                item_ch.valid <= 1'b1;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // Receiver ready: random idling, or held low for the long stall.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // The long stall is timed here, in cycles, independently of the sender,
    // which carries on offering beats until the block backs up.
    initial
    begin
        rx_hold = 1'b0;
        @(hold_results);
        @(negedge clk);
        rx_hold = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        rx_hold = 1'b0;
    end

    // Every accepted request beat gets its expected outcome queued.
    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            outcomes_due.push_back(table_outcome(item_ch.data));
            beats_taken++;
        end
    end

    // Monitor: each result beat is checked against the oldest outcome owed.
    always @(posedge clk)
    begin
        maa_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (outcomes_due.size() == 0)
                note_failure("result beat with no outcome pending");
            else
            begin
                want = outcomes_due.pop_front();
                compare_field("event_res", 64'(want.event_res),
                              64'(result_ch.data.event_res));
                compare_field("slot", 64'(want.slot), 64'(result_ch.data.slot));
                compare_field("unique_count", 64'(want.unique_count),
                              64'(result_ch.data.unique_count));
                compare_field("active_count", 64'(want.active_count),
                              64'(result_ch.data.active_count));
            end
        end
    end

    // Waits until every queued beat has gone in and every result come out.
    task automatic wait_drained();
        while (pending_items.size() != 0 || item_ch.valid || outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    // The timeout register is only touched while the block is idle; the
    // table copy takes the new value at the same time.
    task automatic write_timeout(logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        timeout_ms = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random phase: new timeout, new idling, a fresh address pool and a
    // fresh starting time so that the millisecond clock wraps somewhere.
    task automatic run_phase(logic [31:0] timeout, int beats, int step_max,
                             int tx_idle, int rx_idle, bit with_hold);
        int start_taken;
        wait_drained();
        @(negedge clk);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        write_timeout(timeout);
        foreach (mac_pool[i])
            mac_pool[i] = random_mac();
        air_time_ms = $urandom;
        start_taken = beats_taken;
        for (int n = 0; n < beats; n++)
            pending_items.push_back(random_beat(step_max));
        if (with_hold)
        begin
            while (beats_taken < start_taken + 40)
                @(posedge clk);
            -> hold_results;
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        result_ch.ready = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 58;
        beats_taken = 0;
        fault_count = 0;
        next_slot = 0;
        insertions = '0;
        timeout_ms = TIMEOUT_RESET;
        air_time_ms = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats, run with the timeout left at its reset value.
        // A report on the empty table gives nothing active.
        pending_items.push_back(make_item(OP_REPORT, 1'b0, 12'd0, 8'h00, 48'd0, T0));
        // Rejected frames: not management, one byte too short, empty, and
        // subtypes outside the accepted three.
        pending_items.push_back(make_item(OP_OBSERVE, 1'b0, 12'd24, 8'h80,
                                          48'h0A0B_0C0D_0E0F, T0));
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'd23, 8'h40,
                                          48'h0A0B_0C0D_0E0F, T0));
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'd0, 8'h00,
                                          48'h0A0B_0C0D_0E0F, T0));
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'd100, 8'h10,
                                          48'h0A0B_0C0D_0E0F, T0));
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'd100, 8'h20,
                                          48'h0A0B_0C0D_0E0F, T0));
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'hFFF, 8'hFF,
                                          48'h0A0B_0C0D_0E0F, T0));
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'd100, 8'hC0,
                                          48'h0A0B_0C0D_0E0F, T0));
        // New addresses at the field extremes, one per accepted subtype.
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'd24, 8'h00,
                                          48'd0, 32'd0));
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'hFFF, 8'h4F,
                                          48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'd100, 8'h88,
                                          48'h0123_4567_89AB, T0));
        // A known address is refreshed rather than stored again.
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'd60, 8'h8F, 48'd0, T0));
        // Reports around the timeout boundary and across the time wrap,
        // one with every unused field at its maximum.
        pending_items.push_back(make_item(OP_REPORT, 1'b0, 12'd0, 8'h00, 48'd0, T0));
        pending_items.push_back(make_item(OP_REPORT, 1'b0, 12'd0, 8'h00, 48'd0,
                                          T0 + TIMEOUT_RESET - 1));
        pending_items.push_back(make_item(OP_REPORT, 1'b0, 12'd0, 8'h00, 48'd0,
                                          T0 + TIMEOUT_RESET));
        pending_items.push_back(make_item(OP_REPORT, 1'b1, 12'hFFF, 8'hFF,
                                          48'hFFFF_FFFF_FFFF, T0 - 1));
        pending_items.push_back(make_item(OP_OBSERVE, 1'b1, 12'd30, 8'h40,
                                          48'hFFFF_FFFF_FFFF, 32'd5));
        pending_items.push_back(make_item(OP_REPORT, 1'b0, 12'd0, 8'h00, 48'd0, 32'd6));
        wait_drained();

        // A timeout of 1 ms under a slow receiver, with the long stall; then
        // the longest timeout under a slow sender; then no idling at all,
        // including a zero timeout under which nothing is ever active.
        run_phase(32'd1, 450, 2, 8, 58, 1'b1);
        run_phase(32'hFFFF_FFFF, 450, 5000, 58, 8, 1'b0);
        run_phase(32'd0, 150, 50, 0, 0, 1'b0);
        run_phase($urandom_range(20000, 1), 450, 300, 0, 0, 1'b0);
        run_phase(TIMEOUT_RESET, 300, 20000, 0, 0, 1'b0);

        // Give any stray result time to show up before judging.
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (fault_count == 0 && outcomes_due.size() == 0)
            $display("tb_mac_address_aging_table: clean");
        else
            $display("tb_mac_address_aging_table: errors");
        $finish;
    end
endmodule
